/* hdl/apsp_pkg.sv */
// Shared types and constants for the all-pairs shortest path block.
// Used by apsp_core and all_pairs_shortest_path; depends on nothing else.
package apsp_pkg;

  localparam int CMD_W    = 2;
  localparam int COORD_W  = 4;
  localparam int DIST_W   = 14;
  localparam int ROUTE_W  = 5;
  localparam int VC_W     = 5;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 24;
  localparam int APB_AW   = 3;

  localparam logic [DIST_W-1:0] NO_EDGE = 14'd9999;
  localparam logic [VC_W-1:0]   VC_RESET = 5'd16;

  // Register select is paddr[2]: one register, word aligned
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_COMPUTE = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // Request from the stream front end to the matrix engine
  typedef struct packed {
    logic               load;
    logic               compute;
    logic               read;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [DIST_W-1:0]  weight;
  } apsp_req_t;

  // Engine status back to the front end
  typedef struct packed {
    logic idle;
    logic finish;
  } apsp_stat_t;

endpackage

/* hdl/apsp_core.sv */
// Matrix engine: distance and route memories plus the compute sequencer
// (diagonal clear, symmetrize, Floyd-Warshall). Depends on apsp_pkg.
module apsp_core #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  apsp_pkg::apsp_req_t                   req,
  input  logic [$clog2(MAX_VERTICES)-1:0]       n_last,
  input  logic                                  n_zero,
  input  logic                                  fin_take,
  output apsp_pkg::apsp_stat_t                  stat,
  output logic [apsp_pkg::DIST_W-1:0]           rd_dist,
  output logic [apsp_pkg::ROUTE_W-1:0]          rd_route
);
  import apsp_pkg::*;

  localparam int IW    = $clog2(MAX_VERTICES);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_DIAG     = 9'b000000010,
    ST_SYM_RD   = 9'b000000100,
    ST_SYM_WA   = 9'b000001000,
    ST_SYM_WB   = 9'b000010000,
    ST_FW_FETCH = 9'b000100000,
    ST_FW_PIVOT = 9'b001000000,
    ST_FW_ROW   = 9'b010000000,
    ST_FINISH   = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic [IW-1:0] i, j, k, i_next, j_next, k_next;

  // memories and their registered read data
  logic [DIST_W-1:0]  dist_mem  [DEPTH];
  logic [ROUTE_W-1:0] route_mem [DEPTH];
  logic [DIST_W-1:0]  dist_a_q, dist_b_q;
  logic [ROUTE_W-1:0] route_q;

  logic               ren_a, ren_b, ren_r;
  logic [AW-1:0]      raddr_a, raddr_b;
  logic               dw_en, rw_en;
  logic [AW-1:0]      dw_addr, rw_addr;
  logic [DIST_W-1:0]  dw_data;
  logic [ROUTE_W-1:0] rw_data;

  // relaxation write-back stage
  logic               issue;
  logic               wb_valid, wb_skip;
  logic [IW-1:0]      wb_i, wb_j;
  logic [ROUTE_W-1:0] wb_route;
  logic [DIST_W-1:0]  pivot;
  logic [DIST_W:0]    sum;
  logic [DIST_W-1:0]  sym_val;
  logic [AW-1:0]      req_addr;

  assign req_addr = {IW'(req.row), IW'(req.col)};
  assign sum      = {1'b0, pivot} + {1'b0, dist_a_q};

  // pair value: no edge wins, else the smaller weight
  always_comb begin
    if (dist_a_q == NO_EDGE || dist_b_q == NO_EDGE) begin
      sym_val = NO_EDGE;
    end else if (dist_b_q < dist_a_q) begin
      sym_val = dist_b_q;
    end else begin
      sym_val = dist_a_q;
    end
  end

  // sequencer, memory port steering
  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    ren_a      = 1'b0;
    ren_b      = 1'b0;
    ren_r      = 1'b0;
    raddr_a    = '0;
    raddr_b    = '0;
    dw_en      = 1'b0;
    dw_addr    = '0;
    dw_data    = '0;
    rw_en      = 1'b0;
    rw_addr    = '0;
    rw_data    = '0;
    issue      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req.load) begin
          dw_en   = 1'b1;
          dw_addr = req_addr;
          dw_data = req.weight;
          rw_en   = 1'b1;
          rw_addr = req_addr;
          rw_data = ROUTE_W'(req.col) + 5'd1;
        end
        if (req.read) begin
          ren_a   = 1'b1;
          raddr_a = req_addr;
          ren_r   = 1'b1;
        end
        if (req.compute) begin
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
          state_next = n_zero ? ST_FINISH : ST_DIAG;
        end
      end
      ST_DIAG: begin
        dw_en   = 1'b1;
        dw_addr = {i, i};
        dw_data = '0;
        if (i == n_last) begin
          i_next     = '0;
          state_next = ST_SYM_RD;
        end else begin
          i_next = i + 1'b1;
        end
      end
      ST_SYM_RD: begin
        ren_a      = 1'b1;
        raddr_a    = {i, j};
        ren_b      = 1'b1;
        raddr_b    = {j, i};
        state_next = ST_SYM_WA;
      end
      ST_SYM_WA: begin
        dw_en      = 1'b1;
        dw_addr    = {i, j};
        dw_data    = sym_val;
        state_next = ST_SYM_WB;
      end
      ST_SYM_WB: begin
        dw_en   = 1'b1;
        dw_addr = {j, i};
        dw_data = sym_val;
        if (j == n_last) begin
          j_next = '0;
          if (i == n_last) begin
            i_next     = '0;
            state_next = ST_FW_FETCH;
          end else begin
            i_next     = i + 1'b1;
            state_next = ST_SYM_RD;
          end
        end else begin
          j_next     = j + 1'b1;
          state_next = ST_SYM_RD;
        end
      end
      ST_FW_FETCH: begin
        ren_b      = 1'b1;
        raddr_b    = {i, k};
        state_next = ST_FW_PIVOT;
      end
      ST_FW_PIVOT: begin
        j_next     = '0;
        state_next = ST_FW_ROW;
      end
      ST_FW_ROW: begin
        ren_a   = 1'b1;
        raddr_a = {k, j};
        ren_b   = 1'b1;
        raddr_b = {i, j};
        issue   = 1'b1;
        if (j == n_last) begin
          j_next = '0;
          if (i == n_last) begin
            i_next = '0;
            if (k == n_last) begin
              state_next = ST_FINISH;
            end else begin
              k_next     = k + 1'b1;
              state_next = ST_FW_FETCH;
            end
          end else begin
            i_next     = i + 1'b1;
            state_next = ST_FW_FETCH;
          end
        end else begin
          j_next = j + 1'b1;
        end
      end
      ST_FINISH: begin
        if (fin_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // write back an improved path; never collides with other writes
    if (wb_valid && !wb_skip && sum < {1'b0, dist_b_q}) begin
      dw_en   = 1'b1;
      dw_addr = {wb_i, wb_j};
      dw_data = sum[DIST_W-1:0];
      rw_en   = 1'b1;
      rw_addr = {wb_i, wb_j};
      rw_data = wb_route;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      i        <= '0;
      j        <= '0;
      k        <= '0;
      wb_valid <= 1'b0;
    end else begin
      state    <= state_next;
      i        <= i_next;
      j        <= j_next;
      k        <= k_next;
      wb_valid <= issue;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (state == ST_FW_PIVOT) begin
      pivot <= dist_b_q;
    end
    wb_i     <= i;
    wb_j     <= j;
    wb_skip  <= (i == j) || (i == k) || (j == k);
    wb_route <= ROUTE_W'(k) + 5'd1;
  end

  // distance memory: one write, two reads
  always_ff @(posedge clk) begin
    if (dw_en) begin
      dist_mem[dw_addr] <= dw_data;
    end
    if (ren_a) begin
      dist_a_q <= dist_mem[raddr_a];
    end
    if (ren_b) begin
      dist_b_q <= dist_mem[raddr_b];
    end
  end

  // route memory: one write, one read
  always_ff @(posedge clk) begin
    if (rw_en) begin
      route_mem[rw_addr] <= rw_data;
    end
    if (ren_r) begin
      route_q <= route_mem[raddr_a];
    end
  end

  assign rd_dist     = dist_a_q;
  assign rd_route    = route_q;
  assign stat.idle   = (state == ST_IDLE);
  assign stat.finish = (state == ST_FINISH);

endmodule

/* hdl/all_pairs_shortest_path.sv */
// Top level of the all-pairs shortest path block: APB register, stream
// handshake and result staging around apsp_core. Depends on apsp_pkg.
//
//  Channel  | Direction | Contents
//  ---------+-----------+-------------------------------------------------
//  apb      | in/out    | vertex_count register at address 0
//  s_axis   | in        | commands: load, compute, read, one per transfer
//  m_axis   | out       | one result transfer per command
//
// Load and read may follow back to back while the result path has room; a
// result is offered on m_axis through the staging register and then the
// output register. Compute holds s_axis_tready low through the engine's
// steps (diagonal pass, symmetrize, relaxation per pivot through the
// registered memory read, finish state), longer while its result cannot
// be staged. Reset is synchronous and leaves the matrix contents unset.
// A stalled m_axis holds one result plus one staged behind it.
module all_pairs_shortest_path #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [apsp_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // cmd[1:0], row[5:2], col[9:6], weight[23:10]
  input  logic [apsp_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // distance[13:0], via_vertex[18:14], done_res[19], zero[23:20]
  output logic [apsp_pkg::OUT_W-1:0]   m_axis_tdata
);
  import apsp_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);
  localparam logic [31:0] MaxV = 32'(MAX_VERTICES);

  logic [VC_W-1:0]    vertex_count;
  logic [IW-1:0]      n_last;
  logic               n_zero;
  cmd_t               in_cmd;
  logic [COORD_W-1:0] in_row, in_col;
  logic [DIST_W-1:0]  in_weight, sat_weight;
  logic               in_range, accept, out_free, p_room, p_adv, fin_take;
  logic               p_valid, p_hit, p_done, p_load;
  apsp_req_t          req;
  apsp_stat_t         stat;
  logic [DIST_W-1:0]  rd_dist;
  logic [ROUTE_W-1:0] rd_route;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? 32'(vertex_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VC_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_VERTEX_COUNT) begin
      vertex_count <= pwdata[VC_W-1:0];
    end
  end

  // vertices in use, capped at the built size
  always_comb begin
    if (32'(vertex_count) > MaxV) begin
      n_last = IW'(MAX_VERTICES - 1);
    end else begin
      n_last = IW'(vertex_count - 5'd1);
    end
  end
  assign n_zero = (vertex_count == '0);

  // unpack the command transfer
  assign in_cmd     = cmd_t'(s_axis_tdata[1:0]);
  assign in_row     = s_axis_tdata[5:2];
  assign in_col     = s_axis_tdata[9:6];
  assign in_weight  = s_axis_tdata[23:10];
  assign sat_weight = (in_weight > NO_EDGE) ? NO_EDGE : in_weight;
  assign in_range   = ({28'd0, in_row} < MaxV) && ({28'd0, in_col} < MaxV);

  // handshake: staging register p feeds the output register
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign p_room        = !p_valid || out_free;
  assign p_adv         = p_valid && out_free;
  assign s_axis_tready = stat.idle && p_room;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fin_take      = stat.finish && p_room;
  // a compute stages its result only when the engine finishes
  assign p_load        = (accept && (in_cmd != CMD_COMPUTE)) || fin_take;

  assign req.load    = accept && (in_cmd == CMD_LOAD) && in_range;
  assign req.compute = accept && (in_cmd == CMD_COMPUTE);
  assign req.read    = accept && (in_cmd == CMD_READ) && in_range;
  assign req.row     = in_row;
  assign req.col     = in_col;
  assign req.weight  = sat_weight;

  apsp_core #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .n_last   (n_last),
    .n_zero   (n_zero),
    .fin_take (fin_take),
    .stat     (stat),
    .rd_dist  (rd_dist),
    .rd_route (rd_route)
  );

  // staging and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (p_load) begin
        p_valid <= 1'b1;
      end else if (p_adv) begin
        p_valid <= 1'b0;
      end
      if (out_free) begin
        m_axis_tvalid <= p_valid;
      end
    end
  end

  // staged result kind; read data stays in the core's read registers
  always_ff @(posedge clk) begin
    if (p_load) begin
      p_hit  <= req.read;
      p_done <= fin_take || (in_cmd != CMD_NONE);
    end
    if (p_adv) begin
      m_axis_tdata <= {{(OUT_W - DIST_W - ROUTE_W - 1){1'b0}}, p_done,
                       p_hit ? rd_route : {ROUTE_W{1'b0}},
                       p_hit ? rd_dist : {DIST_W{1'b0}}};
    end
  end

endmodule
